### src/gbmd_pkg.sv
// gbmd_pkg: shared types and constants of the gRPC bytes message deframer.
// No dependencies; every other file of the block refers to it by scoped names.
package gbmd_pkg;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_MAX_PAYLOAD = '0;
  localparam logic [31:0] MAX_PAYLOAD_RST = 32'hffff_ffff;

  // Frame format
  localparam logic [7:0]  TAG_BYTE      = 8'h0a;
  localparam logic [7:0]  VAR_MASK      = 8'h7f;
  localparam logic [7:0]  VAR_CONT      = 8'h80;
  localparam logic [7:0]  VAR_LAST_BAD  = 8'hf0;
  localparam logic [2:0]  VAR_MAX_BYTES = 3'd5;
  localparam logic [32:0] MIN_FRAME     = 33'd7;
  localparam logic [32:0] LEN_LAST_POS  = 33'd4;   // position of last header length byte
  localparam logic [32:0] COUNT_MAX     = 33'h1_ffff_ffff;
  localparam logic [33:0] HDR_OVERHEAD  = 34'd5;   // flag + 4 length bytes
  localparam logic [33:0] VAR_OVERHEAD  = 34'd6;   // flag + length + tag

  // Queue between front and back (depth must be a power of two)
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // A classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       is_tag;
    logic       hi_nib;   // any bit of the last-varint-byte mask set
    logic       cont;     // varint continuation bit
  } byte_class_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/gbmd_cfg.sv
// gbmd_cfg: APB-style register file holding the max_payload limit.
// Depends on gbmd_pkg.
module gbmd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gbmd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [31:0]                      max_payload
);

  logic [31:0]                     max_payload_r;
  logic [gbmd_pkg::CFG_ADDR_W-3:0] reg_idx;
  logic                            hit;

  assign reg_idx = paddr[gbmd_pkg::CFG_ADDR_W-1:2];
  assign hit     = (reg_idx == gbmd_pkg::REG_MAX_PAYLOAD);
  assign pready  = 1'b1;
  assign prdata  = hit ? max_payload_r : 32'd0;
  assign max_payload = max_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= gbmd_pkg::MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && hit) begin
      max_payload_r <= pwdata;
    end
  end

endmodule

### src/gbmd_front.sv
// gbmd_front: input handshake and per-byte classification.
// Depends on gbmd_pkg; feeds gbmd_queue.
module gbmd_front (
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_frame_byte,
  input  logic                   in_frame_end,
  input  gbmd_pkg::q_status_t    q_status,
  output logic                   q_push,
  output gbmd_pkg::byte_class_t  q_wdata
);

  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  always_comb begin
    q_wdata.data    = in_frame_byte;
    q_wdata.last    = in_frame_end;
    q_wdata.is_zero = (in_frame_byte == 8'd0);
    q_wdata.is_tag  = (in_frame_byte == gbmd_pkg::TAG_BYTE);
    q_wdata.hi_nib  = ((in_frame_byte & gbmd_pkg::VAR_LAST_BAD) != 8'd0);
    q_wdata.cont    = ((in_frame_byte & gbmd_pkg::VAR_CONT) != 8'd0);
  end

endmodule

### src/gbmd_queue.sv
// gbmd_queue: short FIFO of classified bytes between front and back.
// Depends on gbmd_pkg.
module gbmd_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  gbmd_pkg::byte_class_t  wdata,
  input  logic                   pop,
  output gbmd_pkg::byte_class_t  rdata,
  output gbmd_pkg::q_status_t    status
);

  gbmd_pkg::byte_class_t             mem_r [gbmd_pkg::QDEPTH];
  logic [gbmd_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [gbmd_pkg::QPTR_W:0]         count_r, count_nxt;

  assign status.full  = (count_r == (gbmd_pkg::QPTR_W+1)'(gbmd_pkg::QDEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### src/gbmd_back.sv
// gbmd_back: frame parser state, error checks and the result register.
// Depends on gbmd_pkg; pops gbmd_queue.
module gbmd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [31:0]            max_payload,
  input  gbmd_pkg::q_status_t    q_status,
  input  gbmd_pkg::byte_class_t  q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_payload_byte,
  output logic                   out_payload_valid,
  output logic                   out_frame_done,
  output logic                   out_frame_error,
  output logic [31:0]            out_payload_length
);

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LENGTH,
    PH_TAG,
    PH_VARINT,
    PH_PAYLOAD
  } phase_t;

  phase_t       phase_r, phase_nxt, ph_u;
  logic [32:0]  bc_r, bc_nxt, bc_u;
  logic [31:0]  hl_r, hl_nxt, hl_u;
  logic [31:0]  fl_r, fl_nxt, fl_u;
  logic [2:0]   vidx_r, vidx_nxt, vidx_u;
  logic [2:0]   vused_r, vused_nxt, vused_u;
  logic [31:0]  pf_r, pf_nxt, pf_u;
  logic         err_r, err_nxt, err_u;

  logic         out_valid_r, out_valid_nxt;
  logic [7:0]   out_byte_r, out_byte_nxt;
  logic         out_pv_r, out_pv_nxt;
  logic         out_done_r, out_done_nxt;
  logic         out_err_r, out_err_nxt;
  logic [31:0]  out_len_r, out_len_nxt;

  logic         fire, fwd, bad, load;
  logic [31:0]  vterm, fl_or;
  logic [2:0]   vidx_inc;
  logic [33:0]  hdr_total, var_total;

  assign fire  = !q_status.empty && (!out_valid_r || !out_stall);
  assign q_pop = fire;

  always_comb begin
    case (vidx_r)
      3'd0:    vterm = {25'd0, q_rdata.data[6:0] & gbmd_pkg::VAR_MASK[6:0]};
      3'd1:    vterm = {18'd0, q_rdata.data[6:0] & gbmd_pkg::VAR_MASK[6:0], 7'd0};
      3'd2:    vterm = {11'd0, q_rdata.data[6:0] & gbmd_pkg::VAR_MASK[6:0], 14'd0};
      3'd3:    vterm = {4'd0, q_rdata.data[6:0] & gbmd_pkg::VAR_MASK[6:0], 21'd0};
      default: vterm = {q_rdata.data[3:0] & gbmd_pkg::VAR_MASK[3:0], 28'd0};
    endcase
  end

  assign fl_or    = fl_r | vterm;
  assign vidx_inc = vidx_r + 3'd1;

  // Per-byte update of the frame state
  always_comb begin
    ph_u    = phase_r;
    hl_u    = hl_r;
    fl_u    = fl_r;
    vidx_u  = vidx_r;
    vused_u = vused_r;
    pf_u    = pf_r;
    err_u   = err_r;
    fwd     = 1'b0;

    if (bc_r == gbmd_pkg::COUNT_MAX) begin
      bc_u  = bc_r;
      err_u = 1'b1;
    end else begin
      bc_u  = bc_r + 33'd1;
    end

    if (!err_u) begin
      case (phase_r)
        PH_FLAG: begin
          if (!q_rdata.is_zero) err_u = 1'b1;
          ph_u = PH_LENGTH;
        end
        PH_LENGTH: begin
          hl_u = {hl_r[23:0], q_rdata.data};
          if (bc_r == gbmd_pkg::LEN_LAST_POS) ph_u = PH_TAG;
        end
        PH_TAG: begin
          if (!q_rdata.is_tag) err_u = 1'b1;
          ph_u = PH_VARINT;
        end
        PH_VARINT: begin
          if (vidx_r >= gbmd_pkg::VAR_MAX_BYTES - 3'd1 && q_rdata.hi_nib) begin
            err_u = 1'b1;
          end else begin
            fl_u   = fl_or;
            vidx_u = vidx_inc;
            if (!q_rdata.cont) begin
              vused_u = vidx_inc;
              ph_u    = PH_PAYLOAD;
              if (fl_or > max_payload) err_u = 1'b1;
            end else if (vidx_inc >= gbmd_pkg::VAR_MAX_BYTES) begin
              err_u = 1'b1;
            end
          end
        end
        default: begin
          if (pf_r >= fl_r) begin
            err_u = 1'b1;
          end else begin
            pf_u = pf_r + 32'd1;
            fwd  = 1'b1;
          end
        end
      endcase
    end

    hdr_total = {2'b00, hl_u} + gbmd_pkg::HDR_OVERHEAD;
    var_total = gbmd_pkg::VAR_OVERHEAD + {31'd0, vused_u} + {2'b00, fl_u};

    // more bytes than the header announced
    if (!err_u && (ph_u == PH_TAG || ph_u == PH_VARINT || ph_u == PH_PAYLOAD) &&
        ({1'b0, bc_u} > hdr_total)) begin
      err_u = 1'b1;
      fwd   = 1'b0;
    end

    bad = err_u || (ph_u != PH_PAYLOAD) || (bc_u < gbmd_pkg::MIN_FRAME) ||
          (pf_u != fl_u) || ({1'b0, bc_u} != hdr_total) ||
          ({1'b0, bc_u} != var_total);
  end

  // Commit, clear at frame end, and the result register
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    hl_nxt    = hl_r;
    fl_nxt    = fl_r;
    vidx_nxt  = vidx_r;
    vused_nxt = vused_r;
    pf_nxt    = pf_r;
    err_nxt   = err_r;
    out_valid_nxt = out_valid_r;
    load      = 1'b0;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (fire) begin
      if (q_rdata.last) begin
        phase_nxt = PH_FLAG;
        bc_nxt    = '0;
        hl_nxt    = '0;
        fl_nxt    = '0;
        vidx_nxt  = '0;
        vused_nxt = '0;
        pf_nxt    = '0;
        err_nxt   = 1'b0;
      end else begin
        phase_nxt = ph_u;
        bc_nxt    = bc_u;
        hl_nxt    = hl_u;
        fl_nxt    = fl_u;
        vidx_nxt  = vidx_u;
        vused_nxt = vused_u;
        pf_nxt    = pf_u;
        err_nxt   = err_u;
      end
      if (fwd || q_rdata.last) begin
        out_valid_nxt = 1'b1;
        load          = 1'b1;
      end
    end

    out_byte_nxt = fwd ? q_rdata.data : 8'd0;
    out_pv_nxt   = fwd;
    out_done_nxt = q_rdata.last;
    out_err_nxt  = q_rdata.last && bad;
    out_len_nxt  = (q_rdata.last && !bad) ? fl_u : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      bc_r        <= '0;
      hl_r        <= '0;
      fl_r        <= '0;
      vidx_r      <= '0;
      vused_r     <= '0;
      pf_r        <= '0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      hl_r        <= hl_nxt;
      fl_r        <= fl_nxt;
      vidx_r      <= vidx_nxt;
      vused_r     <= vused_nxt;
      pf_r        <= pf_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_byte_r <= out_byte_nxt;
      out_pv_r   <= out_pv_nxt;
      out_done_r <= out_done_nxt;
      out_err_r  <= out_err_nxt;
      out_len_r  <= out_len_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_byte   = out_byte_r;
  assign out_payload_valid  = out_pv_r;
  assign out_frame_done     = out_done_r;
  assign out_frame_error    = out_err_r;
  assign out_payload_length = out_len_r;

endmodule

### src/grpc_bytes_message_deframer_top.sv
// grpc_bytes_message_deframer_top: top level of the gRPC bytes deframer.
// Depends on gbmd_pkg, gbmd_cfg, gbmd_front, gbmd_queue and gbmd_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   in       | in_valid / in_stall    | in_frame_byte[7:0], in_frame_end
//   out      | out_valid / out_stall  | out_payload_byte[7:0], out_payload_valid,
//            |                        | out_frame_done, out_frame_error,
//            |                        | out_payload_length[31:0]
//   cfg      | psel/penable/pwrite    | paddr[2:0], pwdata/prdata[31:0]
//
// One byte per cycle sustained while out_stall is low. A byte that causes a
// result passes through the front-to-back queue and then the back's result
// register before it reaches the output channel.
// Reset is synchronous, active low; no clearing pass is needed after it.
// The two-entry queue absorbs an output stall; in_stall rises only when full.
// Bytes that cause no result (header, varint, bytes after an error) are
// consumed without touching the output side.
module grpc_bytes_message_deframer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_frame_byte,
  input  logic                            in_frame_end,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_payload_byte,
  output logic                            out_payload_valid,
  output logic                            out_frame_done,
  output logic                            out_frame_error,
  output logic [31:0]                     out_payload_length,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gbmd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [31:0]            max_payload;
  gbmd_pkg::q_status_t    q_status;
  gbmd_pkg::byte_class_t  q_wdata, q_rdata;
  logic                   q_push, q_pop;

  // max_payload register, word 0
  gbmd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  // accept and classify
  gbmd_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_frame_end  (in_frame_end),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // decouples the input side from output stalls
  gbmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // frame parser and result register
  gbmd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .max_payload        (max_payload),
    .q_status           (q_status),
    .q_rdata            (q_rdata),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_payload_byte   (out_payload_byte),
    .out_payload_valid  (out_payload_valid),
    .out_frame_done     (out_frame_done),
    .out_frame_error    (out_frame_error),
    .out_payload_length (out_payload_length)
  );

endmodule
